// ----- src/arc_pkg.sv -----
package arc_pkg;

	localparam int unsigned TOTAL_W = 40;
	localparam int unsigned COUNT_W = 24;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [1:0] REG_DIRECTION = 2'd0;
	localparam logic [1:0] REG_ADAPTIVE  = 2'd1;
	localparam logic [1:0] REG_FIXED_K   = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_LOG  = 5'b00100,
		ST_WORK = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

endpackage

// ----- src/adaptive_rice_codec.sv -----
// Adaptive Rice codec. direction=0 encodes one 32-bit value (>=1) per request
// into a codeword (bit i = i-th emitted bit); direction=1 takes one code bit per
// request and returns a result only when a value completes or on error.
// In adaptive mode k = floor(log2(total/count)) computed by a radix-2 restoring
// divider that shares one subtractor. A request that needs a fresh adaptive k
// with a nonzero count (every encode, the first bit of a codeword when decoding)
// goes through one accept step, 40 divide steps, one log step per halving of the
// quotient plus one, and one pack step. Other requests take the accept and pack steps only.
// Output is registered; a new request is taken while a result waits, and the
// pack step holds until that result has been handed off.
module adaptive_rice_codec #(
	parameter int unsigned MAX_CODE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [31:0] value_in, [32] code_bit, zero fill
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [103:0] m_tdata, // [63:0] code_bits, [70:64] code_length,
	                              // [102:71] value_out, [103] error
	output logic        m_tvalid_unused_n
);
	localparam int unsigned TW = arc_pkg::TOTAL_W;
	localparam int unsigned CW = arc_pkg::COUNT_W;

	logic        direction_q, adaptive_q;
	logic [4:0]  fixed_k_q;
	logic        wr;
	logic [1:0]  reg_idx;

	arc_pkg::state_t state_q;

	logic [31:0] vin_q;
	logic        bit_q;
	logic        phase_q;
	logic [6:0]  unary_q;
	logic [30:0] racc_q;
	logic [4:0]  ridx_q;
	logic [4:0]  vk_q;
	logic [TW-1:0] total_q;
	logic [CW-1:0] count_q;

	logic [TW-1:0] quo_q;
	logic [CW:0]   rem_q;
	logic [5:0]    step_q;
	logic [4:0]    k_q;
	logic [5:0]    lk_q;

	logic [63:0] obits_q;
	logic [6:0]  olen_q;
	logic [31:0] oval_q;
	logic        oerr_q;
	logic        ovalid_q;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr = psel && penable && pwrite;
	always_comb begin
		case (reg_idx)
			arc_pkg::REG_DIRECTION: prdata = {31'd0, direction_q};
			arc_pkg::REG_ADAPTIVE:  prdata = {31'd0, adaptive_q};
			arc_pkg::REG_FIXED_K:   prdata = {27'd0, fixed_k_q};
			default:                prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			adaptive_q <= 1'b0;
			fixed_k_q <= 5'd0;
		end else if (wr) begin
			case (reg_idx)
				arc_pkg::REG_DIRECTION: direction_q <= pwdata[0];
				arc_pkg::REG_ADAPTIVE:  adaptive_q <= pwdata[0];
				arc_pkg::REG_FIXED_K:   fixed_k_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == arc_pkg::ST_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata = {oerr_q, oval_q, olen_q, obits_q};
	assign m_tvalid_unused_n = 1'b0;

	// k is needed only at a codeword start
	logic start_k;
	assign start_k = !direction_q || (!phase_q && unary_q == 7'd0);

	// divider step: shared subtractor
	logic [CW+1:0] trial;
	logic [CW:0]   rem_sh;
	assign rem_sh = {rem_q[CW-1:0], quo_q[TW-1]};
	assign trial = {1'b0, rem_sh} - {2'b00, count_q};

	// encode datapath
	logic [31:0] vm1;
	logic [31:0] q32;
	logic [7:0]  len8;
	logic [31:0] rmask;
	logic [63:0] ones, rsh;
	assign vm1 = vin_q - 32'd1;
	assign q32 = vm1 >> k_q;
	assign len8 = 8'(q32[6:0]) + 8'd1 + 8'(k_q);
	assign rmask = (32'd1 << k_q) - 32'd1;
	assign ones = (64'd1 << q32[5:0]) - 64'd1;
	assign rsh = 64'(vm1 & rmask) << (7'(q32[5:0]) + 7'd1);

	// decode datapath
	logic [4:0]  dk;
	logic [63:0] dval;
	logic [30:0] racc_n;
	logic [32:0] dval0;
	assign dk = (unary_q == 7'd0) ? k_q : vk_q;
	assign racc_n = racc_q | (31'(bit_q) << ridx_q);
	assign dval = (64'(unary_q) << vk_q) + 64'(racc_n) + 64'd1;
	assign dval0 = 33'(unary_q) + 33'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		logic          st_en;
		logic [32:0]   st_v;
		logic [TW:0]   tsum;
		logic          res_en;
		logic [63:0]   res_bits;
		logic [6:0]    res_len;
		logic [31:0]   res_val;
		logic          res_err;
		if (!arst_n) begin
			state_q <= arc_pkg::ST_IDLE;
			ovalid_q <= 1'b0;
			phase_q <= 1'b0;
			unary_q <= 7'd0;
			racc_q <= 31'd0;
			ridx_q <= 5'd0;
			vk_q <= 5'd0;
			total_q <= '0;
			count_q <= '0;
			vin_q <= 32'd0;
			bit_q <= 1'b0;
			quo_q <= '0;
			rem_q <= '0;
			step_q <= 6'd0;
			k_q <= 5'd0;
			lk_q <= 6'd0;
			obits_q <= 64'd0;
			olen_q <= 7'd0;
			oval_q <= 32'd0;
			oerr_q <= 1'b0;
		end else begin
			st_en = 1'b0;
			st_v = 33'd0;
			res_en = 1'b0;
			res_bits = 64'd0;
			res_len = 7'd0;
			res_val = 32'd0;
			res_err = 1'b0;
			case (state_q)
				arc_pkg::ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						vin_q <= s_tdata[31:0];
						bit_q <= s_tdata[32];
						quo_q <= total_q;
						rem_q <= '0;
						step_q <= 6'd0;
						k_q <= (start_k && adaptive_q) ? 5'd0 : fixed_k_q;
						if (start_k && adaptive_q && count_q != '0)
							state_q <= arc_pkg::ST_DIV;
						else
							state_q <= arc_pkg::ST_WORK;
					end
				end
				arc_pkg::ST_DIV: begin
					if (!trial[CW+1]) begin
						rem_q <= trial[CW:0];
						quo_q <= {quo_q[TW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[TW-2:0], 1'b0};
					end
					step_q <= step_q + 6'd1;
					if (step_q == 6'(TW - 1)) begin
						lk_q <= 6'd0;
						state_q <= arc_pkg::ST_LOG;
					end
				end
				arc_pkg::ST_LOG: begin
					if (quo_q > TW'(1)) begin
						quo_q <= quo_q >> 1;
						lk_q <= lk_q + 6'd1;
					end else begin
						k_q <= (lk_q > 6'd31) ? 5'd31 : lk_q[4:0];
						state_q <= arc_pkg::ST_WORK;
					end
				end
				arc_pkg::ST_WORK: begin
					if (!ovalid_q || m_tready) begin
						state_q <= arc_pkg::ST_IDLE;
						if (!direction_q) begin
							res_en = 1'b1;
							if (vin_q == 32'd0 || q32 > 32'd127
							    || len8 > 8'(MAX_CODE_BITS))
								res_err = 1'b1;
							else begin
								res_bits = ones | ((k_q != 5'd0) ? rsh : 64'd0);
								res_len = len8[6:0];
								st_en = 1'b1;
								st_v = {1'b0, vin_q};
							end
						end else if (!phase_q) begin
							if (unary_q == 7'd0)
								vk_q <= k_q;
							if (bit_q) begin
								if (8'(unary_q) + 8'd2 + 8'(dk) > 8'(MAX_CODE_BITS)) begin
									unary_q <= 7'd0;
									res_en = 1'b1;
									res_err = 1'b1;
								end else
									unary_q <= unary_q + 7'd1;
							end else if (dk == 5'd0) begin
								unary_q <= 7'd0;
								res_en = 1'b1;
								res_val = dval0[31:0];
								st_en = 1'b1;
								st_v = dval0;
							end else begin
								phase_q <= 1'b1;
								racc_q <= '0;
								ridx_q <= '0;
							end
						end else begin
							if (ridx_q + 5'd1 >= vk_q || ridx_q == 5'd31) begin
								phase_q <= 1'b0;
								unary_q <= 7'd0;
								racc_q <= '0;
								ridx_q <= '0;
								res_en = 1'b1;
								if (dval > 64'hFFFF_FFFF)
									res_err = 1'b1;
								else begin
									res_val = dval[31:0];
									st_en = 1'b1;
									st_v = dval[32:0];
								end
							end else begin
								racc_q <= racc_n;
								ridx_q <= ridx_q + 5'd1;
							end
						end
					end
				end
				default: state_q <= arc_pkg::ST_IDLE;
			endcase
			if (res_en) begin
				ovalid_q <= 1'b1;
				obits_q <= res_bits;
				olen_q <= res_len;
				oval_q <= res_val;
				oerr_q <= res_err;
			end else if (m_tready)
				ovalid_q <= 1'b0;
			tsum = {1'b0, total_q} + (TW+1)'(st_v);
			if (st_en) begin
				total_q <= tsum[TW] ? arc_pkg::TOTAL_MAX : tsum[TW-1:0];
				if (count_q != arc_pkg::COUNT_MAX)
					count_q <= count_q + CW'(1);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != arc_pkg::ST_IDLE |-> !s_tready)
		else $error("accept while busy");
	a_len_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[70:64] <= 7'(MAX_CODE_BITS))
		else $error("code length too big");
endmodule

// ----- tb/sv/adaptive_rice_codec_test.sv -----
`timescale 1ns / 100ps

module adaptive_rice_codec_test;

	localparam int MAXB = 64;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic        error;
		logic [31:0] value_out;
		logic [6:0]  code_length;
		logic [63:0] code_bits;
	} rice_result_t;

	logic         clk;
	logic         arst_n;
	logic         psel, penable, pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid;
	logic         s_tready;
	logic [39:0]  s_tdata;   // [31:0] value_in, [32] code_bit, zero fill
	logic         m_tready;
	logic         m_tvalid;
	logic [103:0] m_tdata;   // [63:0] code_bits, [70:64] code_length,
	                         // [102:71] value_out, [103] error
	logic         m_tvalid_unused_n;

	adaptive_rice_codec dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata),
		.m_tvalid_unused_n(m_tvalid_unused_n)
	);

	// predictor state
	logic        cfg_decode, cfg_adaptive;
	logic [4:0]  cfg_k;
	logic        dec_remainder;
	logic [6:0]  dec_ones;
	logic [30:0] dec_rem;
	logic [4:0]  dec_idx;
	logic [4:0]  dec_k;
	logic [39:0] stat_total;
	logic [23:0] stat_count;

	rice_result_t expected_results[$];
	int error_count;
	int idle_gap_pct, stall_pct;
	int quiet_cycles;
	int items_sent;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		error_count++;
	endtask

	function automatic logic [4:0] current_k();
		logic [39:0] avg;
		int k;
		if (!cfg_adaptive) return cfg_k;
		if (stat_count == 0) return 5'd0;
		avg = stat_total / stat_count;
		k = 0;
		while (avg > 1) begin
			avg >>= 1;
			k++;
		end
		return (k > 31) ? 5'd31 : k[4:0];
	endfunction

	function automatic void add_to_stats(input logic [31:0] v);
		logic [40:0] t;
		t = stat_total + v;
		stat_total = t[40] ? arc_pkg::TOTAL_MAX : t[39:0];
		if (stat_count != arc_pkg::COUNT_MAX) stat_count++;
	endfunction

	function automatic rice_result_t error_result();
		rice_result_t r;
		r = '0;
		r.error = 1'b1;
		return r;
	endfunction

	function automatic void clear_decoder();
		dec_remainder = 0;
		dec_ones = 0;
		dec_rem = 0;
		dec_idx = 0;
	endfunction

	function automatic void finish_decode();
		logic [63:0] v;
		rice_result_t r;
		v = (64'(dec_ones) << dec_k) + dec_rem + 64'd1;
		clear_decoder();
		r = '0;
		if (v > 64'hFFFF_FFFF) r.error = 1'b1;
		else begin
			add_to_stats(v[31:0]);
			r.value_out = v[31:0];
		end
		expected_results.push_back(r);
	endfunction

	function automatic void predict_rice(input logic [31:0] val, input logic bit_in);
		logic [63:0] q, len, rem, cw;
		logic [4:0] k;
		rice_result_t r;
		if (!cfg_decode) begin
			if (val == 0) begin
				expected_results.push_back(error_result());
				return;
			end
			k = current_k();
			q = 64'(val - 1) >> k;
			len = q + 1 + k;
			if (len > MAXB) begin
				expected_results.push_back(error_result());
				return;
			end
			rem = 64'(val - 1) & ((64'd1 << k) - 1);
			cw = (q >= 64) ? '1 : ((64'd1 << q) - 1);
			if (k > 0) cw |= rem << (q + 1);
			add_to_stats(val);
			r = '0;
			r.code_bits = cw;
			r.code_length = len[6:0];
			expected_results.push_back(r);
		end else if (!dec_remainder) begin
			if (dec_ones == 0) dec_k = current_k();
			if (bit_in) begin
				dec_ones++;
				if (int'(dec_ones) + 1 + int'(dec_k) > MAXB) begin
					clear_decoder();
					expected_results.push_back(error_result());
				end
			end else if (dec_k == 0) finish_decode();
			else begin
				dec_remainder = 1;
				dec_rem = 0;
				dec_idx = 0;
			end
		end else begin
			dec_rem |= 31'(bit_in) << dec_idx;
			dec_idx++;
			if (dec_idx >= dec_k) finish_decode();
		end
	endfunction

	// result checker and receiver stalls
	always @(posedge clk) begin
		rice_result_t got, exp_r;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_results.size() == 0)
				report($sformatf("unexpected result %h", m_tdata));
			else begin
				exp_r = expected_results.pop_front();
				if (got.code_bits !== exp_r.code_bits)
					report($sformatf("code_bits %h want %h", got.code_bits, exp_r.code_bits));
				if (got.code_length !== exp_r.code_length)
					report($sformatf("code_length %0d want %0d",
						got.code_length, exp_r.code_length));
				if (got.value_out !== exp_r.value_out)
					report($sformatf("value_out %0d want %0d", got.value_out, exp_r.value_out));
				if (got.error !== exp_r.error)
					report($sformatf("error %b want %b", got.error, exp_r.error));
			end
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("adaptive_rice_codec_test: errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			arc_pkg::REG_DIRECTION: cfg_decode = val[0];
			arc_pkg::REG_ADAPTIVE:  cfg_adaptive = val[0];
			arc_pkg::REG_FIXED_K:   cfg_k = val[4:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic configure(input logic dir, input logic adapt, input logic [4:0] k);
		drain();
		write_reg(arc_pkg::REG_DIRECTION, 32'(dir));
		write_reg(arc_pkg::REG_ADAPTIVE, 32'(adapt));
		write_reg(arc_pkg::REG_FIXED_K, 32'(k));
	endtask

	// entered at a falling edge; leaves tvalid high until the next request or idle
	task automatic send_item(input logic [31:0] val, input logic bit_in);
		while ($urandom_range(99) < idle_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, bit_in, val};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_rice(val, bit_in);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(3))
			0: return $urandom_range(1, 16);
			1: return $urandom_range(1, 1000);
			2: return $urandom() >> $urandom_range(31);
			default: return $urandom();
		endcase
	endfunction

	// sends a well-formed codeword for v under the decoder's expected k;
	// a prefix longer than the code limit is cut short
	task automatic send_codeword(input logic [31:0] v, input logic [4:0] k);
		logic [31:0] q;
		logic [31:0] rem;
		q = (v - 1) >> k;
		rem = v - 1;
		for (int i = 0; i < q && i < MAXB; i++) send_item($urandom(), 1'b1);
		send_item($urandom(), 1'b0);
		for (int i = 0; i < k; i++) send_item($urandom(), rem[i]);
	endtask

	task automatic test_encode_directed();
		configure(1'b0, 1'b0, 5'd0);
		send_item(32'd0, 1'b0);
		send_item(32'd1, 1'b0);
		send_item(32'd64, 1'b1);
		send_item(32'd65, 1'b0);
		configure(1'b0, 1'b0, 5'd31);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'd1, 1'b0);
		send_item(32'h8000_0000, 1'b0);
		configure(1'b0, 1'b0, 5'd5);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'd1889, 1'b0);
		send_item(32'd1921, 1'b0);
		configure(1'b0, 1'b1, 5'd0);
		send_item(32'd1, 1'b0);
		send_item(32'd1000, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'd7, 1'b0);
	endtask

	task automatic test_decode_directed();
		configure(1'b1, 1'b0, 5'd0);
		send_codeword(32'd1, 5'd0);
		send_codeword(32'd63, 5'd0);
		for (int i = 0; i < 64; i++) send_item(32'd0, 1'b1);  // prefix too long
		configure(1'b1, 1'b0, 5'd31);
		send_codeword(32'hFFFF_FFFF, 5'd31);
		for (int i = 0; i < 2; i++) send_item(32'd0, 1'b1);
		send_item(32'd0, 1'b0);
		for (int i = 0; i < 31; i++) send_item(32'd0, 1'b1); // overflow
		configure(1'b1, 1'b1, 5'd3);
		send_codeword(32'd1, current_k());
	endtask

	task automatic test_random(input int n_items);
		int start;
		logic [4:0] k;
		start = items_sent;
		while (items_sent - start < n_items) begin
			configure(1'($urandom_range(1)), 1'($urandom_range(1)),
				5'($urandom_range(31)));
			for (int j = 0; j < 12; j++) begin
				if (!cfg_decode) begin
					send_item(($urandom_range(15) == 0) ? 32'd0 : rand_value(),
						1'($urandom_range(1)));
				end else if ($urandom_range(9) == 0) begin
					send_item($urandom(), 1'($urandom_range(1)));
				end else begin
					k = (dec_ones == 0 && !dec_remainder) ? current_k() : dec_k;
					if (dec_ones != 0 || dec_remainder) begin
						send_item($urandom(), 1'($urandom_range(1)));
					end else begin
						send_codeword(($urandom_range(3) == 0) ? rand_value()
							: ((32'd1 << k) + $urandom_range(200)), k);
					end
				end
			end
		end
	endtask

	task automatic test_pause_until_empty();
		configure(1'b0, 1'b1, 5'd0);
		for (int i = 0; i < 6; i++) begin
			send_item(rand_value(), 1'b0);
			s_tvalid <= 1'b0;
			do @(negedge clk); while (expected_results.size() != 0);
		end
	endtask

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		s_tvalid = 0; s_tdata = 0; m_tready = 0;
		error_count = 0; quiet_cycles = 0; items_sent = 0;
		idle_gap_pct = 0; stall_pct = 0;
		cfg_decode = 0; cfg_adaptive = 0; cfg_k = 0;
		dec_k = 0; stat_total = 0; stat_count = 0;
		clear_decoder();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_encode_directed();
		test_decode_directed();
		test_random(55);
		idle_gap_pct = 65;
		test_random(55);
		idle_gap_pct = 0; stall_pct = 65;
		test_random(55);
		idle_gap_pct = 21; stall_pct = 21;
		test_random(55);
		test_pause_until_empty();
		idle_gap_pct = 0; stall_pct = 0;

		drain();
		if (error_count == 0) $display("adaptive_rice_codec_test: clean");
		else $display("adaptive_rice_codec_test: errors");
		$finish;
	end

endmodule
